@@ rtl/core/sapc_pkg.sv @@
`timescale 1ns / 1ps
package sapc_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned FILL_W      = $clog2(TABLE_DEPTH + 1);

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned ENTRY_W = 6;
  localparam int unsigned IN_W    = 2 * KEY_W;
  localparam int unsigned OUT_W   = ENTRY_W + 2 + COUNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // Packed with the entry index in the lowest bits, matching the output beat layout.
  typedef struct packed {
    logic [COUNT_W-1:0] rx_count;
    logic               table_full;
    logic               was_new;
    logic [ENTRY_W-1:0] entry_index;
  } result_t;

endpackage

@@ rtl/core/sapc_ram.sv @@
`timescale 1ns / 1ps
module sapc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/source_address_packet_counter.sv @@
`timescale 1ns / 1ps
// Source address packet counter. Each input beat carries one packet's 128-bit source
// address (upper half in tdata[63:0], lower half in tdata[127:64]). The filled table
// entries are read one per cycle at a shared RAM read address and compared against
// the address. A hit bumps that entry's saturating receive count; a miss appends the
// address with count zero, or, when all TABLE_DEPTH slots are taken, reports table_full
// and leaves the table alone. Time from acceptance to a loaded result grows with
// the fill count, set by the one-entry-per-cycle scan; a hit ends the scan early.
// The input is accepted only while the sequencer is idle, and a finished result
// may wait in the output register while the next address is taken.
module source_address_packet_counter
  import sapc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [IN_W-1:0]  s_axis_tdata_i,  // addr_high[63:0], addr_low[127:64]
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o   // entry_index[5:0], was_new[6],
                                            // table_full[7], rx_count[39:8]
);

  state_e state_q, state_d;

  logic [KEY_W-1:0]  addr_hi_q, addr_lo_q;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [FILL_W-1:0] scan_q, scan_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]  chk_ptr_q, chk_ptr_d;
  result_t           res_q, res_d;
  result_t           out_q;
  logic              out_vld_q, out_vld_d;
  logic              out_load;
  logic              in_accept;

  logic               key_we;
  logic [IDX_W-1:0]   key_waddr;
  logic               cnt_we;
  logic [IDX_W-1:0]   cnt_waddr;
  logic [COUNT_W-1:0] cnt_wdata;
  logic [IDX_W-1:0]   raddr;
  logic [KEY_W-1:0]   key_hi_rdata, key_lo_rdata;
  logic [COUNT_W-1:0] cnt_rdata;
  logic [COUNT_W-1:0] cnt_next;

  logic hit, scan_done, table_is_full;

  assign in_accept     = s_axis_tvalid_i && s_axis_tready_o;
  assign raddr         = scan_q[IDX_W-1:0];
  assign hit           = chk_vld_q && (key_hi_rdata == addr_hi_q) && (key_lo_rdata == addr_lo_q);
  assign scan_done     = (scan_q == fill_q);
  assign table_is_full = (fill_q == FILL_W'(TABLE_DEPTH));
  assign cnt_next      = (cnt_rdata == {COUNT_W{1'b1}}) ? cnt_rdata : cnt_rdata + 1'b1;

  sapc_ram #(.Width(KEY_W), .Depth(TABLE_DEPTH)) u_key_hi_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (addr_hi_q),
    .raddr_i (raddr),
    .rdata_o (key_hi_rdata)
  );

  sapc_ram #(.Width(KEY_W), .Depth(TABLE_DEPTH)) u_key_lo_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (addr_lo_q),
    .raddr_i (raddr),
    .rdata_o (key_lo_rdata)
  );

  sapc_ram #(.Width(COUNT_W), .Depth(TABLE_DEPTH)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (raddr),
    .rdata_o (cnt_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit || scan_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_vld_q || m_axis_tready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    fill_d    = fill_q;
    scan_d    = scan_q;
    chk_vld_d = chk_vld_q;
    chk_ptr_d = chk_ptr_q;
    res_d     = res_q;
    key_we    = 1'b0;
    key_waddr = fill_q[IDX_W-1:0];
    cnt_we    = 1'b0;
    cnt_waddr = fill_q[IDX_W-1:0];
    cnt_wdata = '0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        scan_d    = '0;
        chk_vld_d = 1'b0;
      end
      ST_SCAN: begin
        // The read data in hand belongs to chk_ptr_q; the next read goes out at scan_q.
        if (hit) begin
          chk_vld_d = 1'b0;
          cnt_we    = 1'b1;
          cnt_waddr = chk_ptr_q;
          cnt_wdata = cnt_next;
          res_d     = '{rx_count: cnt_next, table_full: 1'b0, was_new: 1'b0,
                        entry_index: ENTRY_W'(chk_ptr_q)};
        end else if (scan_done) begin
          chk_vld_d = 1'b0;
          if (table_is_full) begin
            res_d = '{rx_count: '0, table_full: 1'b1, was_new: 1'b0,
                      entry_index: '0};
          end else begin
            key_we = 1'b1;
            cnt_we = 1'b1;
            fill_d = fill_q + 1'b1;
            res_d  = '{rx_count: '0, table_full: 1'b0, was_new: 1'b1,
                       entry_index: ENTRY_W'(fill_q)};
          end
        end else begin
          chk_vld_d = 1'b1;
          chk_ptr_d = scan_q[IDX_W-1:0];
          scan_d    = scan_q + 1'b1;
        end
      end
      ST_EMIT: begin
        out_load = !out_vld_q || m_axis_tready_i;
      end
      default: ;
    endcase
  end

  assign out_vld_d = out_load || (out_vld_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      scan_q    <= '0;
      chk_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      scan_q    <= scan_d;
      chk_vld_q <= chk_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      addr_hi_q <= s_axis_tdata_i[KEY_W-1:0];
      addr_lo_q <= s_axis_tdata_i[IN_W-1:KEY_W];
    end
    chk_ptr_q <= chk_ptr_d;
    res_q     <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SCAN) |=> (fill_q == $past(fill_q)))
    else $error("fill count changed outside the scan");

  a_chk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && chk_vld_q) |-> (FILL_W'(chk_ptr_q) < fill_q))
    else $error("compared an entry that was never filled");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.table_full) |-> (!out_q.was_new && out_q.rx_count == '0))
    else $error("full result carries entry data");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready_o)
    else $error("input taken again before the scan ran");

endmodule
